/* hw/rtl/length_checked_frame_deframer_defines.svh */
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define LCFD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define LCFD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/lcfd_pkg.sv */
// Types and constants shared by the deframer modules.
package lcfd_pkg;

  localparam int IDX_W   = 6;   // width of byte_index and frame_length
  localparam int CNT_W   = 8;   // descriptor count width, covers the largest buffer
  localparam int TOTAL_W = 16;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [7:0] SYNC_R     = 8'h52;
  localparam logic [7:0] SYNC_M     = 8'h4D;
  localparam logic [7:0] SYNC_C     = 8'h43;
  localparam logic [7:0] SYNC_T     = 8'h54;
  localparam logic [7:0] MIN_LENGTH = 8'd2;
  localparam logic [7:0] CPL_MASK   = 8'hFF;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  // One finished frame as handed from the parser to the drain side.
  typedef struct packed {
    logic               reject;
    logic [CNT_W-1:0]   count;
    logic [TOTAL_W-1:0] total;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } push_t;

endpackage

/* hw/rtl/lcfd_in_if.sv */
// Received byte channel.
interface lcfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* hw/rtl/lcfd_out_if.sv */
// Result item channel.
interface lcfd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [5:0]  byte_index;
  logic        last;
  logic [5:0]  frame_length;
  logic [15:0] rejected_count;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output last, output frame_length, output rejected_count, input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input last, input frame_length, input rejected_count, output ready);
endinterface

/* hw/rtl/lcfd_ram.sv */
// Generic single write port RAM with registered read.
module lcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/lcfd_front.sv */
// Frame parser: header hunt, length checks, payload capture and checksum.
`include "length_checked_frame_deframer_defines.svh"
module lcfd_front import lcfd_pkg::*; #(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  logic                                        clk,
  input  logic                                        rst,
  lcfd_in_if.sink                                     rx,
  input  logic                                        q_full,
  output push_t                                       push,
  input  logic                                        drain_done,
  output logic                                        wr_en,
  output logic [$clog2(FRAME_BUFFER_BYTES-4)-1:0]     wr_addr,
  output logic [7:0]                                  wr_data
);

  localparam int StoreDepth = FRAME_BUFFER_BYTES - 4;
  localparam int CW = $clog2(StoreDepth + 1);
  localparam int AW = $clog2(StoreDepth);
  localparam logic [8:0]    LenLimit = 9'(FRAME_BUFFER_BYTES - 1);
  localparam logic [CW-1:0] DepthC   = CW'(StoreDepth);

  typedef enum logic [2:0] {
    PH_R, PH_M, PH_C, PH_T, PH_LEN, PH_CPL, PH_PAY, PH_SUM
  } phase_t;

  phase_t              phase, phase_next;
  logic [7:0]          length_byte, length_byte_next;
  logic [CW-1:0]       payload_expected, payload_expected_next;
  logic [CW-1:0]       write_index, write_index_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [TOTAL_W-1:0]  reject_total, reject_total_next;
  logic                busy, busy_next;

  logic                accept;
  logic [7:0]          c;
  logic [CW-1:0]       wi_adv;
  logic [TOTAL_W-1:0]  total_inc;

  // Hold off payload bytes while the buffer still drains the previous frame.
  assign rx.ready = !q_full && !(phase == PH_PAY && busy);
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.rx_byte;
  assign total_inc = reject_total + TOTAL_W'(1);
  assign wi_adv   = (write_index < DepthC) ? write_index + CW'(1) : write_index;

  always_comb begin
    phase_next            = phase;
    length_byte_next      = length_byte;
    payload_expected_next = payload_expected;
    write_index_next      = write_index;
    running_sum_next      = running_sum;
    reject_total_next     = reject_total;
    busy_next             = busy;
    push                  = '0;
    wr_en                 = 1'b0;
    wr_addr               = write_index[AW-1:0];
    wr_data               = c;

    if (drain_done) begin
      busy_next = 1'b0;
    end

    if (accept) begin
      running_sum_next = running_sum + c;
      unique case (phase)
        PH_R: begin
          running_sum_next = c;
          phase_next = (c == SYNC_R) ? PH_M : PH_R;
        end
        PH_M: phase_next = (c == SYNC_M) ? PH_C : PH_R;
        PH_C: phase_next = (c == SYNC_C) ? PH_T : PH_R;
        PH_T: phase_next = (c == SYNC_T) ? PH_LEN : PH_R;
        PH_LEN: begin
          length_byte_next = c;
          if (c < MIN_LENGTH || {1'b0, c} >= LenLimit) begin
            push.valid        = 1'b1;
            push.desc.reject  = 1'b1;
            push.desc.total   = total_inc;
            reject_total_next = total_inc;
            phase_next        = PH_R;
          end else begin
            phase_next = PH_CPL;
          end
        end
        PH_CPL: begin
          if ((c ^ length_byte) != CPL_MASK) begin
            push.valid        = 1'b1;
            push.desc.reject  = 1'b1;
            push.desc.total   = total_inc;
            reject_total_next = total_inc;
            phase_next        = PH_R;
          end else begin
            write_index_next      = '0;
            payload_expected_next = CW'(length_byte - MIN_LENGTH);
            phase_next            = PH_PAY;
          end
        end
        PH_PAY: begin
          wr_en            = (write_index < DepthC);
          write_index_next = wi_adv;
          // A zero payload count still takes one byte before the checksum.
          if (wi_adv >= payload_expected || wi_adv >= DepthC) begin
            phase_next = PH_SUM;
          end
        end
        PH_SUM: begin
          phase_next = PH_R;
          push.valid = 1'b1;
          if (running_sum_next != 8'd0) begin
            write_index_next  = '0;
            push.desc.reject  = 1'b1;
            push.desc.total   = total_inc;
            reject_total_next = total_inc;
          end else begin
            push.desc.reject = 1'b0;
            push.desc.count  = CNT_W'(write_index);
            push.desc.total  = reject_total;
            busy_next        = 1'b1;
          end
        end
        default: phase_next = PH_R;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_R;
      length_byte      <= '0;
      payload_expected <= '0;
      write_index      <= '0;
      running_sum      <= '0;
      reject_total     <= '0;
      busy             <= 1'b0;
    end else begin
      phase            <= phase_next;
      length_byte      <= length_byte_next;
      payload_expected <= payload_expected_next;
      write_index      <= write_index_next;
      running_sum      <= running_sum_next;
      reject_total     <= reject_total_next;
      busy             <= busy_next;
    end
  end

  `LCFD_ASSERT(a_no_write_while_drain, !(wr_en && busy), "payload write while buffer drains")

endmodule

/* hw/rtl/lcfd_queue.sv */
// Short descriptor queue between the parser and the drain side.
`include "length_checked_frame_deframer_defines.svh"
module lcfd_queue import lcfd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t push,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output desc_t head
);

  desc_t              entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp, rp;
  logic [Q_PTR_W:0]   count;

  assign full  = (count == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wp] <= push.desc;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wp <= wp + Q_PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + Q_PTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + (Q_PTR_W + 1)'(1);
        2'b01:   count <= count - (Q_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  `LCFD_ASSERT(a_no_overflow, !(push.valid && full), "descriptor pushed into full queue")
  `LCFD_ASSERT(a_no_underflow, !(pop && empty), "descriptor popped from empty queue")

endmodule

/* hw/rtl/lcfd_back.sv */
// Drain side: turns descriptors into reject items or payload runs.
`include "length_checked_frame_deframer_defines.svh"
module lcfd_back import lcfd_pkg::*; #(
  parameter int STORE_DEPTH = 60
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_empty,
  input  desc_t                          q_head,
  output logic                           pop,
  output logic                           rd_en,
  output logic [$clog2(STORE_DEPTH)-1:0] rd_addr,
  input  logic [7:0]                     rd_data,
  output logic                           drain_done,
  lcfd_out_if.source                     res
);

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic {
    BK_IDLE, BK_READ
  } bk_state_t;

  bk_state_t          state, state_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [TOTAL_W-1:0] total, total_next;

  logic               out_valid, out_valid_next;
  logic               kind, last;
  logic [7:0]         data_byte;
  logic [IDX_W-1:0]   byte_index, frame_length;
  logic [TOTAL_W-1:0] rejected_count;

  logic               load;
  logic               ld_kind, ld_last;
  logic [7:0]         ld_data;
  logic [IDX_W-1:0]   ld_index, ld_length;
  logic [TOTAL_W-1:0] ld_count;

  logic               out_free;
  logic [CW-1:0]      idx_inc;

  assign out_free = !out_valid || res.ready;
  assign idx_inc  = idx + CW'(1);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    cnt_next       = cnt;
    total_next     = total;
    pop            = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = idx_inc[AW-1:0];
    drain_done     = 1'b0;
    load           = 1'b0;
    ld_kind        = KIND_PAYLOAD;
    ld_data        = rd_data;
    ld_index       = IDX_W'(idx);
    ld_last        = (idx_inc == cnt);
    ld_length      = IDX_W'(cnt);
    ld_count       = total;

    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_head.reject) begin
            if (out_free) begin
              pop       = 1'b1;
              load      = 1'b1;
              ld_kind   = KIND_REJECT;
              ld_data   = '0;
              ld_index  = '0;
              ld_last   = 1'b1;
              ld_length = '0;
              ld_count  = q_head.total;
            end
          end else begin
            // Start the run: fetch the first stored byte.
            pop        = 1'b1;
            cnt_next   = CW'(q_head.count);
            total_next = q_head.total;
            idx_next   = '0;
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = BK_READ;
          end
        end
      end
      BK_READ: begin
        if (out_free) begin
          load = 1'b1;
          if (idx_inc == cnt) begin
            drain_done = 1'b1;
            state_next = BK_IDLE;
          end else begin
            idx_next = idx_inc;
            rd_en    = 1'b1;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase

    out_valid_next = load || (out_valid && !res.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    idx   <= idx_next;
    cnt   <= cnt_next;
    total <= total_next;
    if (load) begin
      kind           <= ld_kind;
      data_byte      <= ld_data;
      byte_index     <= ld_index;
      last           <= ld_last;
      frame_length   <= ld_length;
      rejected_count <= ld_count;
    end
  end

  assign res.valid          = out_valid;
  assign res.kind           = kind;
  assign res.data_byte      = data_byte;
  assign res.byte_index     = byte_index;
  assign res.last           = last;
  assign res.frame_length   = frame_length;
  assign res.rejected_count = rejected_count;

  `LCFD_ASSERT_IMPL(a_reject_is_last, out_valid && kind == KIND_REJECT, last, "reject beat without last")
  `LCFD_ASSERT_IMPL(a_read_in_range, rd_en, {1'b0, rd_addr} < (AW + 1)'(STORE_DEPTH), "read past store")

endmodule

/* hw/rtl/length_checked_frame_deframer.sv */
// Top level of the length-checked frame deframer.
//
// Channel rx carries one received byte per beat; channel res carries result
// items. A frame is "RMCT", length L, ~L, payload, checksum; the 8-bit sum of
// all its bytes must be zero. A good frame yields its payload as a run of
// beats with last set on the final one; a bad length, complement or checksum
// yields one reject beat carrying the updated 16-bit reject count.
// Throughput: rx takes one byte per cycle. It stalls only while the payload
// of a new frame arrives before the previous good run has left the payload
// RAM (the RAM holds a single frame), or while the four-entry descriptor
// queue is full.
// A reject beat passes through the descriptor queue and the output register;
// a good run is read from the payload RAM through the output register, then
// one beat per cycle while res is ready.
// When res stalls, the output register holds its beat and the parser keeps
// taking bytes until the queue or the payload RAM is held up.
// Reset (rst, synchronous) returns to the header hunt, clears the reject
// count and the queue; no clearing pass is needed.
module length_checked_frame_deframer import lcfd_pkg::*; #(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  lcfd_in_if.sink    rx,
  lcfd_out_if.source res
);

  localparam int StoreDepth = FRAME_BUFFER_BYTES - 4;
  localparam int AW = $clog2(StoreDepth);

  push_t         push;
  desc_t         q_head;
  logic          q_full, q_empty, pop;
  logic          drain_done;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  lcfd_front #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .q_full     (q_full),
    .push       (push),
    .drain_done (drain_done),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  lcfd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .head  (q_head)
  );

  lcfd_ram #(.WIDTH(8), .DEPTH(StoreDepth)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lcfd_back #(.STORE_DEPTH(StoreDepth)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .drain_done (drain_done),
    .res        (res)
  );

endmodule

/* dv/lcfd_frame_checker.sv */
`timescale 1ns / 100ps
// Watches both deframer channels, predicts each result item and compares.
module lcfd_frame_checker import lcfd_pkg::*; #(
  parameter int BUF_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  lcfd_in_if   rx,
  lcfd_out_if  res,
  output int   errors,
  output int   pending
);

  localparam int STORE_DEPTH = BUF_BYTES - 4;
  localparam logic [3:0][7:0] SYNC_WORD = {SYNC_T, SYNC_C, SYNC_M, SYNC_R};

  typedef enum logic [2:0] {
    HUNT_R, HUNT_M, HUNT_C, HUNT_T, GET_LEN, GET_CPL, GET_BODY, GET_SUM
  } hunt_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [5:0]  byte_index;
    logic        last;
    logic [5:0]  frame_length;
    logic [15:0] rejected_count;
  } result_t;

  hunt_t       hunt;
  logic [7:0]  len_seen;
  logic [7:0]  sum_acc;
  int          body_want;
  int          body_fill;
  logic [7:0]  body_store [STORE_DEPTH];
  logic [15:0] reject_total;
  result_t     result_q [$];

  task automatic flag_mismatch(input string what);
    if (errors < 100) $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  function automatic void push_reject();
    reject_total++;
    result_q.push_back('{kind: KIND_REJECT, data_byte: 8'h00, byte_index: 6'd0,
                         last: 1'b1, frame_length: 6'd0,
                         rejected_count: reject_total});
    hunt = HUNT_R;
  endfunction

  always @(posedge clk) begin
    int k;
    result_t got;
    result_t want;
    logic [7:0] b;
    if (rst) begin
      hunt = HUNT_R;
      len_seen = 8'h00;
      sum_acc = 8'h00;
      body_want = 0;
      body_fill = 0;
      reject_total = 16'h0000;
      result_q.delete();
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        got = '{kind: res.kind, data_byte: res.data_byte, byte_index: res.byte_index,
                last: res.last, frame_length: res.frame_length,
                rejected_count: res.rejected_count};
        if (result_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing expected: kind %0d data 0x%0h",
                                  got.kind, got.data_byte));
        end else begin
          want = result_q.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("data_byte", got.data_byte, want.data_byte);
          check_field("byte_index", got.byte_index, want.byte_index);
          check_field("last", got.last, want.last);
          check_field("frame_length", got.frame_length, want.frame_length);
          check_field("rejected_count", got.rejected_count, want.rejected_count);
        end
      end
      if (rx.valid && rx.ready) begin
        b = rx.rx_byte;
        sum_acc = sum_acc + b;
        case (hunt)
          HUNT_R, HUNT_M, HUNT_C, HUNT_T: begin
            if (hunt == HUNT_R) sum_acc = b;
            // drop a mismatching byte outright, even an R
            hunt = (b == SYNC_WORD[hunt[1:0]]) ? hunt_t'(hunt + 1) : HUNT_R;
          end
          GET_LEN: begin
            len_seen = b;
            if (len_seen < MIN_LENGTH || len_seen >= BUF_BYTES - 1) push_reject();
            else hunt = GET_CPL;
          end
          GET_CPL: begin
            if ((b ^ len_seen) != CPL_MASK) begin
              push_reject();
            end else begin
              body_fill = 0;
              body_want = len_seen - 2;
              hunt = GET_BODY;
            end
          end
          GET_BODY: begin
            // a length of two still stores one byte
            if (body_fill < STORE_DEPTH) begin
              body_store[body_fill] = b;
              body_fill++;
            end
            if (body_fill >= body_want || body_fill >= STORE_DEPTH) hunt = GET_SUM;
          end
          default: begin
            hunt = HUNT_R;
            if (sum_acc != 8'h00) begin
              body_fill = 0;
              push_reject();
            end else begin
              for (k = 0; k < body_fill; k++)
                result_q.push_back('{kind: KIND_PAYLOAD, data_byte: body_store[k],
                                     byte_index: k[5:0], last: (k + 1 == body_fill),
                                     frame_length: body_fill[5:0],
                                     rejected_count: reject_total});
            end
          end
        endcase
      end
    end
    pending = result_q.size();
  end

endmodule

/* dv/tb_length_checked_frame_deframer.sv */
`timescale 1ns / 100ps
// Testbench top: byte stream stimulus, result backpressure, watchdog and verdict.
module tb_length_checked_frame_deframer import lcfd_pkg::*;;

  localparam int BUF_BYTES    = 64;
  localparam int TARGET_BYTES = 470;
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         errors;
  int         pending;
  int         sent = 0;
  int         idle_cycles = 0;
  bit         quiet = 1'b0;
  bit         hold_request = 1'b0;
  bit         pressed = 1'b0;
  logic [7:0] frame_sum;

  lcfd_in_if  rx ();
  lcfd_out_if res ();

  length_checked_frame_deframer #(.FRAME_BUFFER_BYTES(BUF_BYTES)) uut (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res)
  );

  lcfd_frame_checker #(.BUF_BYTES(BUF_BYTES)) frame_check (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .res(res),
    .errors(errors),
    .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
      @(posedge clk);
      if (res.valid && res.ready) stall_left = quiet ? 0 : $urandom_range(0, 3);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      rx.valid <= 1'b0;
      rx.rx_byte <= 8'($urandom_range(0, 255));
    end
    @(negedge clk);
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    frame_sum = frame_sum + b;
    sent++;
  endtask

  // Stop after the byte that the deframer rejects on.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cpl,
                            input logic [7:0] sum_skew, input fill_t fill);
    int n;
    logic [7:0] chk;
    frame_sum = 8'h00;
    send_byte(SYNC_R);
    send_byte(SYNC_M);
    send_byte(SYNC_C);
    send_byte(SYNC_T);
    send_byte(len);
    if (len < MIN_LENGTH || len >= BUF_BYTES - 1) return;
    send_byte(cpl);
    if ((len ^ cpl) != CPL_MASK) return;
    n = (len > 8'd3) ? len - 2 : 1;
    repeat (n) begin
      case (fill)
        FILL_ZERO: send_byte(8'h00);
        FILL_ONES: send_byte(8'hFF);
        default:   send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    chk = 8'h00 - frame_sum + sum_skew;
    send_byte(chk);
  endtask

  task automatic send_random_frame();
    int pick;
    int band;
    logic [7:0] len;
    logic [7:0] flip;
    pick = $urandom_range(0, 99);
    band = $urandom_range(0, 19);
    if (band < 14) len = 8'($urandom_range(2, 8));
    else if (band < 18) len = 8'($urandom_range(9, 40));
    else len = 8'($urandom_range(41, BUF_BYTES - 2));
    flip = 8'($urandom_range(1, 255));
    if (pick < 70) begin
      send_frame(len, ~len, 8'h00, FILL_RANDOM);
    end else if (pick < 80) begin
      send_frame(len, ~len, flip, FILL_RANDOM);
    end else if (pick < 87) begin
      len = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                 : 8'($urandom_range(BUF_BYTES - 1, 255));
      send_frame(len, ~len, 8'h00, FILL_RANDOM);
    end else if (pick < 93) begin
      send_frame(len, ~len ^ flip, 8'h00, FILL_RANDOM);
    end else if (pick < 97) begin
      // broken header: a partial sync word, then a random byte
      band = $urandom_range(1, 3);
      send_byte(SYNC_R);
      if (band > 1) send_byte(SYNC_M);
      if (band > 2) send_byte(SYNC_C);
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    rx.valid = 1'b0;
    rx.rx_byte = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // the second R only breaks the header, so this whole frame is lost
    send_byte(SYNC_R);
    send_frame(8'd2, 8'hFD, 8'h00, FILL_RANDOM);
    send_frame(8'd2, 8'hFD, 8'h00, FILL_ONES);
    send_frame(8'd0, 8'hFF, 8'h00, FILL_RANDOM);
    send_frame(8'd5, 8'h00, 8'h00, FILL_RANDOM);
    send_frame(8'(BUF_BYTES - 2), ~8'(BUF_BYTES - 2), 8'h00, FILL_ZERO);
    send_frame(8'd3, 8'hFC, 8'h01, FILL_RANDOM);
    send_frame(8'hFF, 8'h00, 8'h00, FILL_RANDOM);

    while (sent < TARGET_BYTES) begin
      quiet = ($urandom_range(0, 7) == 0);
      if (!pressed && sent > TARGET_BYTES / 2) begin
        // hold the result side and offer five frames, so that input stalls
        pressed = 1'b1;
        hold_request = 1'b1;
        repeat (5) send_frame(8'd40, ~8'd40, 8'h00, FILL_RANDOM);
      end else begin
        send_random_frame();
      end
    end
    @(negedge clk);
    rx.valid <= 1'b0;
    quiet = 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
